@@ hdl/fts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg: shared definitions for the frame time smoother
// Widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package fts_pkg;

    // history depth and duration width (depth is a power of two)
    localparam int MAX_WINDOW    = 64;
    localparam int DURATION_BITS = 24;

    localparam int PTR_BITS  = $clog2(MAX_WINDOW);
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = DURATION_BITS + PTR_BITS;
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    // fixed field widths
    localparam int TIME_BITS     = 40;
    localparam int GAME_BITS     = 48;
    localparam int FRAME_BITS    = 32;
    localparam int WIN_REG_BITS  = 7;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 40;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_DUR  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPIKE_LIMIT  = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_TIME   = 8'd3;

    // reset values
    localparam logic [WIN_REG_BITS-1:0]  RST_WINDOW_SIZE = 7'd1;
    localparam logic [DURATION_BITS-1:0] RST_DEFAULT_DUR = 24'd16667;
    localparam logic [DURATION_BITS-1:0] RST_SPIKE_LIMIT = 24'd200000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_OUT
    } fts_state_t;

endpackage

@@ hdl/fts_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_divider: serial restoring divider
// Divides the window sum by the entry count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fts_divider
    import fts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0] divisor,
    output logic                done,
    output logic [SUM_BITS-1:0] quotient
);

    logic [SUM_BITS-1:0]  quo_reg,  quo_next;
    logic [CNT_BITS-1:0]  rem_reg,  rem_next;
    logic [CNT_BITS-1:0]  div_reg,  div_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS:0]    trial;
    logic                 fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = STEP_BITS'(SUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits CNT_BITS
            rem_next  = fits ? CNT_BITS'(trial - {1'b0, div_reg}) : trial[CNT_BITS-1:0];
            quo_next  = {quo_reg[SUM_BITS-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/frame_time_smoother.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_smoother: moving-average frame time filter
// Measures the time between readings, replaces spikes, keeps a history ring
// in block memory and reports the truncated mean, game time and frame count.
//
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    timestamp
//   m_       out  m_valid / m_ready    smoothed, measured, spike, game, frame
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item runs from its input transfer through the accept cycle with
// the ring read, the update state with the write back, the serial divider
// (30 quotient bits and the done cycle), then the load into the output
// register; the next reading is accepted only after that load. A waiting
// result does not block the next accept; only its final load waits for
// the output to be free.
// After reset no memory pass is needed: the single default entry is held
// aside in a flag until the ring slot is overwritten.
// ----------------------------------------------------------------------------
module frame_time_smoother
    import fts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // input item
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [TIME_BITS-1:0]     s_timestamp,
    // result item
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DURATION_BITS-1:0] m_smoothed_duration,
    output logic [DURATION_BITS-1:0] m_measured_duration,
    output logic                     m_spike_seen,
    output logic [GAME_BITS-1:0]     m_game_time,
    output logic [FRAME_BITS-1:0]    m_frame_count,
    // configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    fts_state_t state_reg, state_next;

    // configuration
    logic [WIN_REG_BITS-1:0]  window_size_reg;
    logic [DURATION_BITS-1:0] default_dur_reg;
    logic [DURATION_BITS-1:0] spike_limit_reg;

    // filter state
    logic [TIME_BITS-1:0]     prev_reading_reg;
    logic [PTR_BITS-1:0]      head_reg;
    logic [CNT_BITS-1:0]      count_reg;
    logic [SUM_BITS-1:0]      sum_reg;
    logic [DURATION_BITS-1:0] newest_reg;
    logic                     seed_reg;
    logic [GAME_BITS-1:0]     game_time_reg;
    logic [FRAME_BITS-1:0]    frame_count_reg;

    // per-item working registers
    logic [DURATION_BITS-1:0] dur_reg;
    logic                     spike_reg;
    logic                     full_reg;
    logic                     use_seed_reg;
    logic [CNT_BITS-1:0]      win_reg;

    // output register
    logic                     m_valid_reg;
    logic [DURATION_BITS-1:0] m_smoothed_reg;
    logic [DURATION_BITS-1:0] m_measured_reg;
    logic                     m_spike_reg;

    // ring memory
    logic [DURATION_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [DURATION_BITS-1:0] rd_data_reg;

    logic                     s_fire, cfg_fire, clear_hist;
    logic                     div_start, mem_we, load_out;
    logic                     div_done;
    logic [SUM_BITS-1:0]      div_quotient;
    logic [CNT_BITS-1:0]      win;
    logic [PTR_BITS-1:0]      oldest_ptr, wr_ptr;
    logic [TIME_BITS-1:0]     raw_dur;
    logic                     raw_spike;
    logic [DURATION_BITS-1:0] old_dur;
    logic [SUM_BITS-1:0]      sum_next;
    logic [CNT_BITS-1:0]      count_next;

    assign s_fire     = s_valid && s_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign clear_hist = cfg_fire &&
                        (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_DEFAULT_DUR);

    // effective window: zero acts as one, clipped to the ring depth
    always_comb begin
        if (window_size_reg == '0) begin
            win = CNT_BITS'(1);
        end else if (CNT_BITS'(window_size_reg) > CNT_BITS'(MAX_WINDOW)) begin
            win = CNT_BITS'(MAX_WINDOW);
        end else begin
            win = CNT_BITS'(window_size_reg);
        end
    end

    // oldest entry, modulo the power-of-two depth
    assign oldest_ptr = head_reg + PTR_BITS'(1) - count_reg[PTR_BITS-1:0];
    assign wr_ptr     = head_reg + PTR_BITS'(1);

    // raw duration wraps, so a backward clock reads as a spike
    assign raw_dur   = s_timestamp - prev_reading_reg;
    assign raw_spike = raw_dur > TIME_BITS'(spike_limit_reg);

    // window sum update
    assign old_dur    = use_seed_reg ? default_dur_reg : rd_data_reg;
    assign sum_next   = sum_reg - (full_reg ? SUM_BITS'(old_dur) : '0) + SUM_BITS'(dur_reg);
    assign count_next = full_reg ? win_reg : count_reg + CNT_BITS'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_fire)   state_next = S_UPDATE;
            S_UPDATE:               state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_OUT;
            S_OUT:    if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
            end
            S_UPDATE: begin
                div_start = 1'b1;
                mem_we    = 1'b1;
            end
            S_DIV: begin
            end
            S_OUT: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            window_size_reg  <= RST_WINDOW_SIZE;
            default_dur_reg  <= RST_DEFAULT_DUR;
            spike_limit_reg  <= RST_SPIKE_LIMIT;
            prev_reading_reg <= '0;
            head_reg         <= '0;
            count_reg        <= CNT_BITS'(1);
            sum_reg          <= SUM_BITS'(RST_DEFAULT_DUR);
            newest_reg       <= RST_DEFAULT_DUR;
            seed_reg         <= 1'b1;
            game_time_reg    <= '0;
            frame_count_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration transfer
            if (cfg_fire) begin
                case (cfg_index)
                    REG_WINDOW_SIZE: window_size_reg  <= cfg_data[WIN_REG_BITS-1:0];
                    REG_DEFAULT_DUR: default_dur_reg  <= cfg_data[DURATION_BITS-1:0];
                    REG_SPIKE_LIMIT: spike_limit_reg  <= cfg_data[DURATION_BITS-1:0];
                    REG_START_TIME:  prev_reading_reg <= cfg_data[TIME_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // history clear: one default entry, held in the seed flag
            if (clear_hist) begin
                head_reg  <= '0;
                count_reg <= CNT_BITS'(1);
                seed_reg  <= 1'b1;
                if (cfg_index == REG_DEFAULT_DUR) begin
                    sum_reg    <= SUM_BITS'(cfg_data[DURATION_BITS-1:0]);
                    newest_reg <= cfg_data[DURATION_BITS-1:0];
                end else begin
                    sum_reg    <= SUM_BITS'(default_dur_reg);
                    newest_reg <= default_dur_reg;
                end
            end

            if (s_fire) begin
                prev_reading_reg <= s_timestamp;
            end

            // ring write back
            if (mem_we) begin
                head_reg   <= wr_ptr;
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                newest_reg <= dur_reg;
                if (wr_ptr == '0) begin
                    seed_reg <= 1'b0;
                end
            end

            // result into the output register
            if (load_out) begin
                m_valid_reg     <= 1'b1;
                game_time_reg   <= game_time_reg + GAME_BITS'(div_quotient);
                frame_count_reg <= frame_count_reg + FRAME_BITS'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-item datapath, captured at the input transfer
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            spike_reg    <= raw_spike;
            // a non-spike duration is below the 24-bit limit
            dur_reg      <= raw_spike ? newest_reg : raw_dur[DURATION_BITS-1:0];
            full_reg     <= count_reg >= win;
            use_seed_reg <= seed_reg && (oldest_ptr == '0);
            win_reg      <= win;
        end
        if (load_out) begin
            m_smoothed_reg <= div_quotient[DURATION_BITS-1:0];
            m_measured_reg <= dur_reg;
            m_spike_reg    <= spike_reg;
        end
    end

    // history ring: registered read of the oldest entry at the transfer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wr_ptr] <= dur_reg;
        end
        if (s_fire) begin
            rd_data_reg <= ring_mem[oldest_ptr];
        end
    end

    fts_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid             = m_valid_reg;
    assign m_smoothed_duration = m_smoothed_reg;
    assign m_measured_duration = m_measured_reg;
    assign m_spike_seen        = m_spike_reg;
    assign m_game_time         = game_time_reg;
    assign m_frame_count       = frame_count_reg;

endmodule

@@ hdl/fts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_checker: port-level assertions for the frame time smoother
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
module fts_checker
    import fts_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [DURATION_BITS-1:0] m_smoothed_duration,
    input logic [DURATION_BITS-1:0] m_measured_duration,
    input logic                     m_spike_seen,
    input logic [GAME_BITS-1:0]     m_game_time,
    input logic [FRAME_BITS-1:0]    m_frame_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed_duration) &&
        $stable(m_measured_duration) && $stable(m_spike_seen) &&
        $stable(m_game_time) && $stable(m_frame_count))
        else $error("result changed while stalled");

    // one item in flight: an input transfer is followed by a busy cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // frame count only steps by one, with a new result shown
    a_frame_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(m_frame_count) |->
        m_valid && m_frame_count == $past(m_frame_count) + 32'd1)
        else $error("frame count step wrong");

    // game time grows by the reported mean
    a_game_time: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(m_frame_count) |->
        m_game_time == $past(m_game_time) + GAME_BITS'(m_smoothed_duration))
        else $error("game time does not match mean");

endmodule

bind frame_time_smoother fts_checker u_fts_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_smoothed_duration (m_smoothed_duration),
    .m_measured_duration (m_measured_duration),
    .m_spike_seen        (m_spike_seen),
    .m_game_time         (m_game_time),
    .m_frame_count       (m_frame_count)
);

@@ bench/frame_time_smoother_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_smoother_checker: result predictor and scoreboard
// Watches the config, input and result channels of the frame time smoother.
// It keeps its own copy of the register set and the duration history, works
// out the result of every accepted reading, and compares each result
// transfer field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module frame_time_smoother_checker
    import fts_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [TIME_BITS-1:0]     s_timestamp,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [DURATION_BITS-1:0] m_smoothed_duration,
    input  logic [DURATION_BITS-1:0] m_measured_duration,
    input  logic                     m_spike_seen,
    input  logic [GAME_BITS-1:0]     m_game_time,
    input  logic [FRAME_BITS-1:0]    m_frame_count,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       mismatch_count,
    output int                       frames_in_flight
);

    typedef struct packed {
        logic [DURATION_BITS-1:0] smoothed;
        logic [DURATION_BITS-1:0] measured;
        logic                     spike;
        logic [GAME_BITS-1:0]     game;
        logic [FRAME_BITS-1:0]    frames;
    } frame_report_t;

    localparam logic [DURATION_BITS-1:0] LONGEST_DURATION = '1;

    // register copies
    logic [WIN_REG_BITS-1:0]  window_reg;
    logic [DURATION_BITS-1:0] default_reg;
    logic [DURATION_BITS-1:0] limit_reg;

    // history and running totals
    logic [TIME_BITS-1:0]     last_reading;
    logic [DURATION_BITS-1:0] history [MAX_WINDOW];
    logic [PTR_BITS-1:0]      newest_slot;
    logic [CNT_BITS-1:0]      held;
    logic [SUM_BITS-1:0]      history_sum;
    logic [DURATION_BITS-1:0] newest_kept;
    logic [GAME_BITS-1:0]     game_clock;
    logic [FRAME_BITS-1:0]    frames_done;

    frame_report_t expected_frames [$];

    // history back to a single default entry
    task automatic reload_history();
        newest_slot          = '0;
        held                 = CNT_BITS'(1);
        history[0]           = default_reg;
        history_sum          = SUM_BITS'(default_reg);
        newest_kept          = default_reg;
    endtask

    task automatic apply_write(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_WINDOW_SIZE: begin
                window_reg = data[WIN_REG_BITS-1:0];
                reload_history();
            end
            REG_DEFAULT_DUR: begin
                default_reg = data[DURATION_BITS-1:0];
                reload_history();
            end
            REG_SPIKE_LIMIT: limit_reg = data[DURATION_BITS-1:0];
            REG_START_TIME:  last_reading = data[TIME_BITS-1:0];
            default: ;
        endcase
    endtask

    // one frame step: measure, replace spikes, update the ring, average
    task automatic smooth_frame(input logic [TIME_BITS-1:0] now, output frame_report_t rep);
        logic [TIME_BITS-1:0]     raw;
        logic [DURATION_BITS-1:0] kept;
        logic                     spike;
        logic [CNT_BITS-1:0]      span;
        logic [PTR_BITS-1:0]      oldest;
        logic [SUM_BITS-1:0]      mean;

        raw          = now - last_reading;
        last_reading = now;
        spike        = raw > TIME_BITS'(limit_reg);
        if (spike)
            kept = newest_kept;
        else if (raw > TIME_BITS'(LONGEST_DURATION))
            kept = LONGEST_DURATION;
        else
            kept = raw[DURATION_BITS-1:0];

        // zero acts as one, oversize clamps to the ring depth
        if (window_reg == '0)
            span = CNT_BITS'(1);
        else if (window_reg > MAX_WINDOW)
            span = CNT_BITS'(MAX_WINDOW);
        else
            span = window_reg;

        if (held >= span) begin
            oldest      = newest_slot + 1'b1 - held[PTR_BITS-1:0];
            history_sum = history_sum - history[oldest];
            held        = span;
        end else begin
            held = held + 1'b1;
        end
        newest_slot          = newest_slot + 1'b1;
        history[newest_slot] = kept;
        history_sum          = history_sum + kept;
        newest_kept          = kept;

        mean        = history_sum / held;
        game_clock  = game_clock + mean;
        frames_done = frames_done + 1'b1;

        rep.smoothed = mean[DURATION_BITS-1:0];
        rep.measured = kept;
        rep.spike    = spike;
        rep.game     = game_clock;
        rep.frames   = frames_done;
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // result transfer is checked before the input transfer of the same edge
    always @(posedge aclk) begin
        frame_report_t want;
        if (!aresetn) begin
            window_reg   = RST_WINDOW_SIZE;
            default_reg  = RST_DEFAULT_DUR;
            limit_reg    = RST_SPIKE_LIMIT;
            last_reading = '0;
            game_clock   = '0;
            frames_done  = '0;
            for (int i = 0; i < MAX_WINDOW; i++)
                history[i] = '0;
            reload_history();
            expected_frames.delete();
            mismatch_count   = 0;
            frames_in_flight = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);

            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no frame outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_frames[0];
                    expected_frames.delete(0);
                    report_field("smoothed_duration", 64'(want.smoothed), 64'(m_smoothed_duration));
                    report_field("measured_duration", 64'(want.measured), 64'(m_measured_duration));
                    report_field("spike_seen",        64'(want.spike),    64'(m_spike_seen));
                    report_field("game_time",         64'(want.game),     64'(m_game_time));
                    report_field("frame_count",       64'(want.frames),   64'(m_frame_count));
                end
            end

            if (s_valid && s_ready) begin
                smooth_frame(s_timestamp, want);
                expected_frames.insert(expected_frames.size(), want);
            end
            frames_in_flight = expected_frames.size();
        end
    end

endmodule

@@ bench/frame_time_smoother_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_smoother_test: top-level bench for the frame time smoother
// Drives timestamp readings and register writes with random idle cycles on
// both channels: a directed opener over the edge cases, then phases of
// random readings under varied window, default, spike and start settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module frame_time_smoother_test;
    import fts_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_FRAMES  = 85;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 2000;

    // indexes that address no register
    localparam logic [CFG_IDX_BITS-1:0] UNUSED_INDEX_LOW  = REG_START_TIME + 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] UNUSED_INDEX_HIGH = '1;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [TIME_BITS-1:0]     s_timestamp;
    logic                     m_valid;
    logic                     m_ready;
    logic [DURATION_BITS-1:0] m_smoothed_duration;
    logic [DURATION_BITS-1:0] m_measured_duration;
    logic                     m_spike_seen;
    logic [GAME_BITS-1:0]     m_game_time;
    logic [FRAME_BITS-1:0]    m_frame_count;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int                       mismatch_count;
    int                       frames_in_flight;
    int                       send_idle_pct;
    int                       recv_idle_pct;
    logic [TIME_BITS-1:0]     last_stamp;

    frame_time_smoother u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_timestamp         (s_timestamp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_smoothed_duration (m_smoothed_duration),
        .m_measured_duration (m_measured_duration),
        .m_spike_seen        (m_spike_seen),
        .m_game_time         (m_game_time),
        .m_frame_count       (m_frame_count),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    frame_time_smoother_checker u_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_timestamp         (s_timestamp),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_smoothed_duration (m_smoothed_duration),
        .m_measured_duration (m_measured_duration),
        .m_spike_seen        (m_spike_seen),
        .m_game_time         (m_game_time),
        .m_frame_count       (m_frame_count),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .frames_in_flight    (frames_in_flight)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // give up after a long run of cycles with no transfer on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // one reading transfer, with an optional idle gap ahead of it
    task automatic push_reading(input logic [TIME_BITS-1:0] stamp);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_timestamp = stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        last_stamp = stamp;
    endtask

    task automatic step_by(input logic [TIME_BITS-1:0] delta);
        push_reading(last_stamp + delta);
    endtask

    // only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stop sending and let every outstanding frame come back
    task automatic wait_for_quiet();
        s_valid = 1'b0;
        while (frames_in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] random_word();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[CFG_DATA_BITS-1:0];
    endfunction

    // mostly plausible frame gaps, plus spikes, stalls, backward steps and noise
    function automatic logic [TIME_BITS-1:0] next_stamp(input logic [TIME_BITS-1:0] prev,
                                                        input logic [DURATION_BITS-1:0] lim);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return prev + $urandom_range(0, lim);
        else if (pick < 70)
            return prev + lim + $urandom_range(1, 1000);
        else if (pick < 74)
            return prev + lim;
        else if (pick < 78)
            return prev;
        else if (pick < 84)
            return prev - $urandom_range(1, 1000);
        else if (pick < 89)
            return random_word();
        else
            return prev + $urandom_range(0, 2000);
    endfunction

    initial begin : stimulus
        logic [WIN_REG_BITS-1:0]  win;
        logic [DURATION_BITS-1:0] dflt;
        logic [DURATION_BITS-1:0] lim;
        logic [TIME_BITS-1:0]     start;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_timestamp   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 15;
        recv_idle_pct = 15;
        last_stamp    = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: exact default gap, gap at the limit, just over it,
        // no gap, backward clock, huge jump, then a wrap past the top
        push_reading(40'd16667);
        step_by(40'd200000);
        step_by(40'd200001);
        step_by(40'd0);
        push_reading(40'd100);
        push_reading('1);
        push_reading(40'd5);

        // short window filling up then evicting
        wait_for_quiet();
        write_reg(REG_WINDOW_SIZE, 40'd3);
        step_by(40'd1000);
        step_by(40'd2000);
        step_by(40'd4000);
        step_by(40'd8000);

        // zero window acts as one
        wait_for_quiet();
        write_reg(REG_WINDOW_SIZE, 40'd0);
        step_by(40'd3000);
        step_by(40'd500);

        // window beyond the ring depth
        wait_for_quiet();
        write_reg(REG_WINDOW_SIZE, 40'd127);
        step_by(40'd10);
        step_by(40'd20);

        // zero default and zero limit: any nonzero gap is a spike
        wait_for_quiet();
        write_reg(REG_DEFAULT_DUR, 40'd0);
        write_reg(REG_SPIKE_LIMIT, 40'd0);
        write_reg(REG_WINDOW_SIZE, 40'd2);
        step_by(40'd0);
        step_by(40'd1);

        // default, limit and start time at the top of their range
        wait_for_quiet();
        write_reg(REG_DEFAULT_DUR, 40'hFF_FFFF);
        write_reg(REG_SPIKE_LIMIT, 40'hFF_FFFF);
        write_reg(REG_START_TIME, '1);
        last_stamp = '1;
        step_by(40'hFF_FFFF);
        step_by(40'h100_0000);

        // writes to unused indexes change nothing
        wait_for_quiet();
        write_reg(UNUSED_INDEX_LOW, '1);
        write_reg(UNUSED_INDEX_HIGH, '1);
        step_by(40'd7);

        // random phases under varied settings
        for (int p = 0; p < PHASES; p++) begin
            wait_for_quiet();
            case (p)
                0:       win = 7'd64;
                1:       win = 7'($urandom_range(2, 63));
                2:       win = 7'($urandom_range(65, 127));
                3:       win = 7'd1;
                4:       win = 7'd0;
                6:       win = 7'd2;
                7:       win = 7'd64;
                default: win = 7'($urandom_range(0, 127));
            endcase
            case (p % 4)
                0:       lim = RST_SPIKE_LIMIT;
                1:       lim = 24'($urandom);
                2:       lim = '1;
                default: lim = 24'($urandom_range(0, 5000));
            endcase
            case (p % 3)
                0:       dflt = 24'($urandom);
                1:       dflt = '1;
                default: dflt = 24'($urandom_range(0, 40000));
            endcase
            start = random_word();

            // high bits of the data word carry noise the block must drop
            write_reg(REG_SPIKE_LIMIT,
                      CFG_DATA_BITS'({random_word() >> DURATION_BITS, lim}));
            write_reg(REG_DEFAULT_DUR,
                      CFG_DATA_BITS'({random_word() >> DURATION_BITS, dflt}));
            write_reg(REG_WINDOW_SIZE,
                      CFG_DATA_BITS'({random_word() >> WIN_REG_BITS, win}));
            write_reg(REG_START_TIME, start);
            if (p == 3)
                write_reg(CFG_IDX_BITS'($urandom_range(UNUSED_INDEX_LOW, UNUSED_INDEX_HIGH)),
                          random_word());
            last_stamp = start;

            // one phase with no idle cycles on either side
            send_idle_pct = (p == 5) ? 0 : 15;
            recv_idle_pct = (p == 5) ? 0 : 15;

            for (int i = 0; i < PHASE_FRAMES; i++) begin
                if (p == 3 && i == PHASE_FRAMES / 2)
                    wait_for_quiet();
                push_reading(next_stamp(last_stamp, lim));
            end
        end

        // drain and give the verdict
        s_valid = 1'b0;
        while (frames_in_flight != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && frames_in_flight == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/fts_pkg.sv
hdl/fts_divider.sv
hdl/frame_time_smoother.sv
hdl/fts_checker.sv
bench/frame_time_smoother_checker.sv
bench/frame_time_smoother_test.sv
